[design/mtep_pkg.sv]
// ----------------------------------------------------------------------------
// mtep_pkg: shared types and constants of the MIDI track event parser
// Parse phases, result kinds, error codes, stream widths and the result word.
// ----------------------------------------------------------------------------
package mtep_pkg;

    localparam int HEADER_BYTES_DEF = 8;

    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 3;

    localparam int DELTA_W     = 28;
    localparam int HCOUNT_W    = 4;
    localparam int DLEN_W      = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCOUNT_W    = 3;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_DELTA  = 3'd1,
        PH_STATUS = 3'd2,
        PH_DATA1  = 3'd3,
        PH_DATA2  = 3'd4,
        PH_MTYPE  = 3'd5,
        PH_MLEN   = 3'd6,
        PH_BODY   = 3'd7
    } phase_t;

    localparam logic [2:0] KIND_EVENT = 3'd0;
    localparam logic [2:0] KIND_MHEAD = 3'd1;
    localparam logic [2:0] KIND_MBODY = 3'd2;
    localparam logic [2:0] KIND_OK    = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    localparam logic [1:0] ERR_DELTA_LONG = 2'd0;
    localparam logic [1:0] ERR_BAD_STATUS = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED  = 2'd2;
    localparam logic [1:0] ERR_NO_END     = 2'd3;

    localparam logic [7:0] STATUS_META  = 8'hFF;
    localparam logic [7:0] SYSTEM_FIRST = 8'hF0;
    localparam logic [7:0] META_END     = 8'h2F;
    localparam logic [3:0] TYPE_PITCH   = 4'hE;
    localparam logic [3:0] TYPE_NOTEOFF = 4'h8;
    localparam logic [3:0] TYPE_CTRL    = 4'hB;
    localparam logic [DLEN_W-1:0] DLEN_MAX = 2'd3;

    typedef struct packed {
        logic [2:0]         kind;
        logic [DELTA_W-1:0] delta_ticks;
        logic [7:0]         status_byte;
        logic [7:0]         first_data;
        logic [7:0]         second_data;
        logic               running_used;
        logic [7:0]         meta_kind;
        logic [7:0]         meta_length;
        logic [7:0]         body_byte;
        logic [1:0]         error_code;
        logic               last_of_run;
    } result_t;

    function automatic logic two_data(input logic [7:0] st);
        logic [3:0] t;
        t = st[7:4];
        return ((t >= TYPE_NOTEOFF) && (t <= TYPE_CTRL)) || (t == TYPE_PITCH);
    endfunction

endpackage

[design/midi_track_event_parser.sv]
// ----------------------------------------------------------------------------
// midi_track_event_parser: byte-wise MIDI track chunk event parser
// Skips the chunk header, decodes delta times, running status, channel,
// system and meta events, and reports track end or errors.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata                                   tuser       tlast
// s_axis   in   data_byte                               first_byte  final_byte
// m_axis   out  delta_ticks..error_code (80 bits)       kind        last_of_run
//
// One byte is taken per cycle while s_axis_tready is high, decoded in that cycle;
// its zero, one or two result words go into a four-word output queue.
// s_axis_tready is high while the queue has room for two words, so a stream
// with one result per byte runs at one byte per clock even under light stalls.
// rst_n clears all parser state and empties the queue asynchronously.
// ----------------------------------------------------------------------------
module midi_track_event_parser #(
    parameter int HEADER_BYTES = mtep_pkg::HEADER_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] data_byte
    input  logic [mtep_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] first_byte
    input  logic [mtep_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [27:0] delta_ticks, [35:28] status_byte, [43:36] first_data,
    // [51:44] second_data, [52] running_used, [60:53] meta_kind,
    // [68:61] meta_length, [76:69] body_byte, [78:77] error_code, [79] zero
    output logic [mtep_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [2:0] kind
    output logic [mtep_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                             m_axis_tlast
);

    import mtep_pkg::*;

    localparam phase_t PH_INIT = (HEADER_BYTES == 0) ? PH_DELTA : PH_HEADER;
    localparam logic [HCOUNT_W:0] HDR_N = (HCOUNT_W + 1)'(HEADER_BYTES);

    logic [7:0] data_byte;
    logic       accept;
    logic       pop;

    phase_t              phase_reg, phase_next, eff_phase, t_phase;
    logic [HCOUNT_W-1:0] hcount_reg, hcount_next, eff_hcount, t_hcount, hcount_inc;
    logic [DELTA_W-1:0]  dacc_reg, dacc_next, eff_dacc, t_dacc, dacc_base;
    logic [DLEN_W-1:0]   dlen_reg, dlen_next, eff_dlen, t_dlen;
    logic [7:0]          prev_reg, prev_next, eff_prev, t_prev;
    logic [7:0]          cur_reg, cur_next, eff_cur, t_cur;
    logic [7:0]          left_reg, left_next, eff_left, t_left;
    logic [7:0]          held_reg, held_next, eff_held, t_held;
    logic [7:0]          mkind_reg, mkind_next, eff_mkind, t_mkind;
    logic                run_reg, run_next, eff_run, t_run;
    logic                end_reg, end_next, eff_end, t_end;
    logic                err_reg, err_next, eff_err, t_err;

    result_t             take_res, fin_res, res0, res1;
    logic                take_emit, fin_emit;
    logic [1:0]          res_cnt;

    result_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QCOUNT_W-1:0] count_reg, count_next;
    result_t             head;

    assign data_byte     = s_axis_tdata;
    assign s_axis_tready = (count_reg <= QCOUNT_W'(QUEUE_DEPTH - 2));
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = (count_reg != '0);
    assign pop           = m_axis_tvalid & m_axis_tready;

    // state as seen by this word, after an optional track restart
    always_comb
    begin
        if (s_axis_tuser[0])
        begin
            eff_phase  = PH_INIT;
            eff_hcount = '0;
            eff_dacc   = '0;
            eff_dlen   = '0;
            eff_prev   = '0;
            eff_cur    = '0;
            eff_left   = '0;
            eff_held   = '0;
            eff_mkind  = '0;
            eff_run    = 1'b0;
            eff_end    = 1'b0;
            eff_err    = 1'b0;
        end
        else
        begin
            eff_phase  = phase_reg;
            eff_hcount = hcount_reg;
            eff_dacc   = dacc_reg;
            eff_dlen   = dlen_reg;
            eff_prev   = prev_reg;
            eff_cur    = cur_reg;
            eff_left   = left_reg;
            eff_held   = held_reg;
            eff_mkind  = mkind_reg;
            eff_run    = run_reg;
            eff_end    = end_reg;
            eff_err    = err_reg;
        end
    end

    assign hcount_inc = eff_hcount + HCOUNT_W'(1);
    assign dacc_base  = (eff_dlen == '0) ? '0 : eff_dacc;

    // next state
    always_comb
    begin
        t_phase  = eff_phase;
        t_hcount = eff_hcount;
        t_dacc   = eff_dacc;
        t_dlen   = eff_dlen;
        t_prev   = eff_prev;
        t_cur    = eff_cur;
        t_left   = eff_left;
        t_held   = eff_held;
        t_mkind  = eff_mkind;
        t_run    = eff_run;
        t_end    = eff_end;
        t_err    = eff_err;
        if (!eff_err)
        begin
            case (eff_phase)
                PH_HEADER:
                begin
                    t_hcount = hcount_inc;
                    if ({1'b0, hcount_inc} >= HDR_N)
                    begin
                        t_hcount = '0;
                        t_phase  = PH_DELTA;
                    end
                end
                PH_DELTA:
                begin
                    t_dacc = {dacc_base[DELTA_W-8:0], data_byte[6:0]};
                    if (data_byte[7])
                    begin
                        if (eff_dlen == DLEN_MAX)
                        begin
                            t_err = 1'b1;
                        end
                        else
                        begin
                            t_dlen = eff_dlen + DLEN_W'(1);
                        end
                    end
                    else
                    begin
                        t_dlen  = '0;
                        t_phase = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    if (!data_byte[7])
                    begin
                        if (eff_prev == '0)
                        begin
                            t_err = 1'b1;
                        end
                        else
                        begin
                            t_cur = eff_prev;
                            t_run = 1'b1;
                            if (two_data(eff_prev))
                            begin
                                t_held  = data_byte;
                                t_phase = PH_DATA2;
                            end
                            else
                            begin
                                t_end   = 1'b0;
                                t_phase = PH_DELTA;
                            end
                        end
                    end
                    else
                    begin
                        t_cur = data_byte;
                        t_run = 1'b0;
                        if (data_byte == STATUS_META)
                        begin
                            t_phase = PH_MTYPE;
                        end
                        else if (data_byte >= SYSTEM_FIRST)
                        begin
                            t_end   = 1'b0;
                            t_phase = PH_DELTA;
                        end
                        else
                        begin
                            t_prev  = data_byte;
                            t_phase = two_data(data_byte) ? PH_DATA1 : PH_DATA2;
                        end
                    end
                end
                PH_DATA1:
                begin
                    t_held  = data_byte;
                    t_phase = PH_DATA2;
                end
                PH_DATA2:
                begin
                    t_end   = 1'b0;
                    t_phase = PH_DELTA;
                end
                PH_MTYPE:
                begin
                    t_mkind = data_byte;
                    t_phase = PH_MLEN;
                end
                PH_MLEN:
                begin
                    t_end   = (eff_mkind == META_END);
                    t_left  = data_byte;
                    t_phase = (data_byte == '0) ? PH_DELTA : PH_BODY;
                end
                PH_BODY:
                begin
                    t_left = eff_left - 8'd1;
                    if (eff_left == 8'd1)
                    begin
                        t_phase = PH_DELTA;
                    end
                end
                default:
                begin
                    t_phase = eff_phase;
                end
            endcase
        end
    end

    // results of this word
    always_comb
    begin
        take_res  = '0;
        take_emit = 1'b0;
        if (!eff_err)
        begin
            case (eff_phase)
                PH_DELTA:
                begin
                    if (data_byte[7] && (eff_dlen == DLEN_MAX))
                    begin
                        take_emit           = 1'b1;
                        take_res.kind       = KIND_ERROR;
                        take_res.error_code = ERR_DELTA_LONG;
                    end
                end
                PH_STATUS:
                begin
                    if (!data_byte[7])
                    begin
                        if (eff_prev == '0)
                        begin
                            take_emit           = 1'b1;
                            take_res.kind       = KIND_ERROR;
                            take_res.error_code = ERR_BAD_STATUS;
                        end
                        else if (!two_data(eff_prev))
                        begin
                            take_emit             = 1'b1;
                            take_res.kind         = KIND_EVENT;
                            take_res.delta_ticks  = eff_dacc;
                            take_res.status_byte  = eff_prev;
                            take_res.first_data   = data_byte;
                            take_res.running_used = 1'b1;
                        end
                    end
                    else if ((data_byte != STATUS_META) && (data_byte >= SYSTEM_FIRST))
                    begin
                        take_emit            = 1'b1;
                        take_res.kind        = KIND_EVENT;
                        take_res.delta_ticks = eff_dacc;
                        take_res.status_byte = data_byte;
                    end
                end
                PH_DATA2:
                begin
                    take_emit             = 1'b1;
                    take_res.kind         = KIND_EVENT;
                    take_res.delta_ticks  = eff_dacc;
                    take_res.status_byte  = eff_cur;
                    take_res.running_used = eff_run;
                    if (two_data(eff_cur))
                    begin
                        take_res.first_data  = eff_held;
                        take_res.second_data = data_byte;
                    end
                    else
                    begin
                        take_res.first_data = data_byte;
                    end
                end
                PH_MLEN:
                begin
                    take_emit            = 1'b1;
                    take_res.kind        = KIND_MHEAD;
                    take_res.delta_ticks = eff_dacc;
                    take_res.status_byte = STATUS_META;
                    take_res.meta_kind   = eff_mkind;
                    take_res.meta_length = data_byte;
                end
                PH_BODY:
                begin
                    take_emit            = 1'b1;
                    take_res.kind        = KIND_MBODY;
                    take_res.delta_ticks = eff_dacc;
                    take_res.status_byte = STATUS_META;
                    take_res.meta_kind   = eff_mkind;
                    take_res.body_byte   = data_byte;
                end
                default:
                begin
                    take_emit = 1'b0;
                end
            endcase
        end

        fin_res  = '0;
        fin_emit = s_axis_tlast && !t_err;
        if (t_phase == PH_HEADER)
        begin
            fin_res.kind       = KIND_ERROR;
            fin_res.error_code = ERR_NO_END;
        end
        else if ((t_phase != PH_DELTA) || (t_dlen != '0))
        begin
            fin_res.kind       = KIND_ERROR;
            fin_res.error_code = ERR_TRUNCATED;
        end
        else if (t_end)
        begin
            fin_res.kind = KIND_OK;
        end
        else
        begin
            fin_res.kind       = KIND_ERROR;
            fin_res.error_code = ERR_NO_END;
        end

        res0    = take_emit ? take_res : fin_res;
        res1    = fin_res;
        res_cnt = {1'b0, take_emit} + {1'b0, fin_emit};
        res0.last_of_run = (res_cnt == 2'd1);
        res1.last_of_run = 1'b1;
    end

    // clear everything after the final word of a track
    always_comb
    begin
        if (s_axis_tlast)
        begin
            phase_next  = PH_INIT;
            hcount_next = '0;
            dacc_next   = '0;
            dlen_next   = '0;
            prev_next   = '0;
            cur_next    = '0;
            left_next   = '0;
            held_next   = '0;
            mkind_next  = '0;
            run_next    = 1'b0;
            end_next    = 1'b0;
            err_next    = 1'b0;
        end
        else
        begin
            phase_next  = t_phase;
            hcount_next = t_hcount;
            dacc_next   = t_dacc;
            dlen_next   = t_dlen;
            prev_next   = t_prev;
            cur_next    = t_cur;
            left_next   = t_left;
            held_next   = t_held;
            mkind_next  = t_mkind;
            run_next    = t_run;
            end_next    = t_end;
            err_next    = t_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_INIT;
            hcount_reg <= '0;
            dacc_reg   <= '0;
            dlen_reg   <= '0;
            prev_reg   <= '0;
            cur_reg    <= '0;
            left_reg   <= '0;
            held_reg   <= '0;
            mkind_reg  <= '0;
            run_reg    <= 1'b0;
            end_reg    <= 1'b0;
            err_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            dacc_reg   <= dacc_next;
            dlen_reg   <= dlen_next;
            prev_reg   <= prev_next;
            cur_reg    <= cur_next;
            left_reg   <= left_next;
            held_reg   <= held_next;
            mkind_reg  <= mkind_next;
            run_reg    <= run_next;
            end_reg    <= end_next;
            err_reg    <= err_next;
        end
    end

    // output queue
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(res_cnt);
            count_next  = count_next + QCOUNT_W'(res_cnt);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
            count_next  = count_next - QCOUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (res_cnt != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (accept && (res_cnt == 2'd2))
        begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
        end
    end

    assign head = queue_reg[rd_ptr_reg];

    assign m_axis_tdata = {1'b0, head.error_code, head.body_byte, head.meta_length,
                           head.meta_kind, head.running_used, head.second_data,
                           head.first_data, head.status_byte, head.delta_ticks};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last_of_run;

endmodule

[tb/midi_track_event_parser_checker.sv]
// ----------------------------------------------------------------------------
// midi_track_event_parser_checker: result predictor and scoreboard
// Watches the byte stream into the parser and computes the event, meta, track
// and error words each accepted byte must produce. Each output word is compared
// field by field with the oldest expected word. Failures and the number of
// words still outstanding go back to the testbench top.
// ----------------------------------------------------------------------------
module midi_track_event_parser_checker #(
    parameter int HEADER_BYTES = mtep_pkg::HEADER_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [mtep_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [mtep_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                             s_axis_tlast,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [mtep_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [mtep_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input  logic                             m_axis_tlast,
    output int                               mismatches,
    output int                               words_pending
);

    import mtep_pkg::*;

    phase_t             phase;
    logic [3:0]         hdr_count;
    logic [DELTA_W-1:0] delta_acc;
    logic [DLEN_W-1:0]  delta_len;
    logic [7:0]         prev_status;
    logic [7:0]         cur_status;
    logic [7:0]         body_left;
    logic [7:0]         held_data;
    logic [7:0]         held_meta;
    logic               running;
    logic               end_seen;
    logic               any_event;
    logic               err_latched;

    result_t            step_words [2];
    int                 step_count;
    result_t            expected_words [$];
    int                 error_total;

    function automatic logic carries_two_data(input logic [7:0] st);
        return ((st[7:4] >= TYPE_NOTEOFF) && (st[7:4] <= TYPE_CTRL))
               || (st[7:4] == TYPE_PITCH);
    endfunction

    task automatic clear_parser();
        phase       = (HEADER_BYTES == 0) ? PH_DELTA : PH_HEADER;
        hdr_count   = '0;
        delta_acc   = '0;
        delta_len   = '0;
        prev_status = '0;
        cur_status  = '0;
        body_left   = '0;
        held_data   = '0;
        held_meta   = '0;
        running     = 1'b0;
        end_seen    = 1'b0;
        any_event   = 1'b0;
        err_latched = 1'b0;
    endtask

    task automatic queue_result(input logic [2:0] kind, input logic [7:0] st,
                                input logic [7:0] d1, input logic [7:0] d2,
                                input logic run, input logic [7:0] mk,
                                input logic [7:0] ml, input logic [7:0] body,
                                input logic [1:0] err);
        result_t r;
        if (step_count >= 2)
            return;
        r.kind         = kind;
        r.delta_ticks  = (kind <= KIND_MBODY) ? delta_acc : '0;
        r.status_byte  = st;
        r.first_data   = d1;
        r.second_data  = d2;
        r.running_used = run;
        r.meta_kind    = mk;
        r.meta_length  = ml;
        r.body_byte    = body;
        r.error_code   = err;
        r.last_of_run  = 1'b0;
        step_words[step_count] = r;
        step_count++;
    endtask

    task automatic flag_parse_error(input logic [1:0] code);
        queue_result(KIND_ERROR, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, code);
        err_latched = 1'b1;
    endtask

    task automatic close_channel_event(input logic [7:0] d1, input logic [7:0] d2);
        queue_result(KIND_EVENT, cur_status, d1, d2, running, 8'h00, 8'h00, 8'h00, 2'd0);
        end_seen  = 1'b0;
        any_event = 1'b1;
        phase     = PH_DELTA;
    endtask

    task automatic advance_parser(input logic [7:0] b);
        case (phase)
            PH_HEADER:
            begin
                hdr_count = hdr_count + 4'd1;
                if (hdr_count >= HEADER_BYTES)
                begin
                    hdr_count = '0;
                    phase     = PH_DELTA;
                end
            end
            PH_DELTA:
            begin
                if (delta_len == 0)
                    delta_acc = '0;
                delta_acc = {delta_acc[DELTA_W-8:0], b[6:0]};
                if (b[7])
                begin
                    if (delta_len == DLEN_MAX)
                        flag_parse_error(ERR_DELTA_LONG);
                    else
                        delta_len = delta_len + DLEN_W'(1);
                end
                else
                begin
                    delta_len = '0;
                    phase     = PH_STATUS;
                end
            end
            PH_STATUS:
            begin
                if (!b[7])
                begin
                    if (prev_status == 8'h00)
                        flag_parse_error(ERR_BAD_STATUS);
                    else
                    begin
                        cur_status = prev_status;
                        running    = 1'b1;
                        if (carries_two_data(cur_status))
                        begin
                            held_data = b;
                            phase     = PH_DATA2;
                        end
                        else
                            close_channel_event(b, 8'h00);
                    end
                end
                else
                begin
                    cur_status = b;
                    running    = 1'b0;
                    if (b == STATUS_META)
                        phase = PH_MTYPE;
                    else if (b >= SYSTEM_FIRST)
                        close_channel_event(8'h00, 8'h00);
                    else
                    begin
                        prev_status = b;
                        phase       = carries_two_data(b) ? PH_DATA1 : PH_DATA2;
                    end
                end
            end
            PH_DATA1:
            begin
                held_data = b;
                phase     = PH_DATA2;
            end
            PH_DATA2:
            begin
                if (carries_two_data(cur_status))
                    close_channel_event(held_data, b);
                else
                    close_channel_event(b, 8'h00);
            end
            PH_MTYPE:
            begin
                held_meta = b;
                phase     = PH_MLEN;
            end
            PH_MLEN:
            begin
                queue_result(KIND_MHEAD, STATUS_META, 8'h00, 8'h00, 1'b0, held_meta, b,
                             8'h00, 2'd0);
                end_seen  = (held_meta == META_END);
                any_event = 1'b1;
                body_left = b;
                phase     = (b == 8'h00) ? PH_DELTA : PH_BODY;
            end
            default:
            begin
                queue_result(KIND_MBODY, STATUS_META, 8'h00, 8'h00, 1'b0, held_meta, 8'h00,
                             b, 2'd0);
                body_left = body_left - 8'd1;
                if (body_left == 8'h00)
                    phase = PH_DELTA;
            end
        endcase
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic starts, input logic ends);
        step_count = 0;
        if (starts)
            clear_parser();
        if (!err_latched)
            advance_parser(b);
        if (ends)
        begin
            if (!err_latched)
            begin
                if (phase == PH_HEADER)
                    flag_parse_error(ERR_NO_END);
                else if ((phase != PH_DELTA) || (delta_len != 0))
                    flag_parse_error(ERR_TRUNCATED);
                else if (end_seen)
                    queue_result(KIND_OK, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00,
                                 2'd0);
                else
                    flag_parse_error(ERR_NO_END);
            end
            clear_parser();
        end
        if (step_count > 0)
            step_words[step_count-1].last_of_run = 1'b1;
        for (int i = 0; i < step_count; i++)
            expected_words.insert(expected_words.size(), step_words[i]);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("checker: %s mismatch at %0t, expected %0h, got %0h",
                 what, $time, want, got);
        error_total++;
    endtask

    task automatic compare_word(input logic [OUT_TDATA_W-1:0] data,
                                input logic [OUT_TUSER_W-1:0] kind_got, input logic last_got);
        result_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch("unexpected word", 32'd0, {29'd0, kind_got});
            return;
        end
        want = expected_words.pop_front();
        if (kind_got !== want.kind)
            report_mismatch("kind", 32'(want.kind), 32'(kind_got));
        if (data[27:0] !== want.delta_ticks)
            report_mismatch("delta_ticks", 32'(want.delta_ticks), 32'(data[27:0]));
        if (data[35:28] !== want.status_byte)
            report_mismatch("status_byte", 32'(want.status_byte), 32'(data[35:28]));
        if (data[43:36] !== want.first_data)
            report_mismatch("first_data", 32'(want.first_data), 32'(data[43:36]));
        if (data[51:44] !== want.second_data)
            report_mismatch("second_data", 32'(want.second_data), 32'(data[51:44]));
        if (data[52] !== want.running_used)
            report_mismatch("running_used", 32'(want.running_used), 32'(data[52]));
        if (data[60:53] !== want.meta_kind)
            report_mismatch("meta_kind", 32'(want.meta_kind), 32'(data[60:53]));
        if (data[68:61] !== want.meta_length)
            report_mismatch("meta_length", 32'(want.meta_length), 32'(data[68:61]));
        if (data[76:69] !== want.body_byte)
            report_mismatch("body_byte", 32'(want.body_byte), 32'(data[76:69]));
        if (data[78:77] !== want.error_code)
            report_mismatch("error_code", 32'(want.error_code), 32'(data[78:77]));
        if (data[79] !== 1'b0)
            report_mismatch("pad bit", 32'd0, 32'(data[79]));
        if (last_got !== want.last_of_run)
            report_mismatch("last_of_run", 32'(want.last_of_run), 32'(last_got));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_words.delete();
            error_total = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                compare_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
        mismatches    <= error_total;
        words_pending <= expected_words.size();
    end

endmodule

[tb/tb_midi_track_event_parser.sv]
// ----------------------------------------------------------------------------
// tb_midi_track_event_parser: stream testbench of the MIDI track event parser
// Feeds short directed tracks, then random track chunks, most well formed and
// some broken (cut short, no end marker, long delta, orphan running status,
// noise, restarted or unterminated), with random gaps and output stalls.
// The checker predicts and compares every word; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_midi_track_event_parser;
    import mtep_pkg::*;

    localparam int STIM_BYTES  = 850;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 20;

    typedef enum int {
        FLAW_NONE,
        FLAW_TRUNCATED,
        FLAW_NO_END,
        FLAW_LONG_DELTA,
        FLAW_ORPHAN_DATA,
        FLAW_NOISE,
        FLAW_SECOND_FIRST,
        FLAW_NO_FINAL
    } flaw_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;
    int                     mismatches;
    int                     words_pending;

    logic                   sender_calm;
    logic                   receiver_calm = 1'b0;
    int                     stall_left = 0;
    int                     idle_cycles = 0;
    int                     bytes_sent;
    logic [7:0]             gen_status;
    logic                   big_meta_due;
    logic [7:0]             track_q [$];
    flaw_t                  flaw;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    midi_track_event_parser u_dut (.*);

    midi_track_event_parser_checker u_checker (.*);

    always @(negedge clk)
    begin : receiver_stalls
        int roll;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 299) == 0)
            receiver_calm <= !receiver_calm;
        if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (receiver_calm || (roll >= 25))
            m_axis_tready <= 1'b1;
        else
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= (roll < 3) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_midi_track_event_parser: errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (sender_calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [27:0] pick_ticks();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 28'($urandom_range(0, 127));
        if (roll < 82)
            return 28'($urandom_range(128, 16383));
        if (roll < 94)
            return 28'($urandom_range(16384, 2097151));
        if (roll < 97)
            return 28'hFFFFFFF;
        return 28'($urandom_range(2097152, 28'hFFFFFFF));
    endfunction

    function automatic logic [7:0] pick_data();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic starts, input logic ends,
                             input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= starts;
        s_axis_tlast  <= ends;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (words_pending != 0)
            @(negedge clk);
    endtask

    task automatic append_byte(input logic [7:0] value);
        track_q = {track_q, value};
    endtask

    task automatic push_delta(input logic [27:0] ticks);
        int groups;
        groups = (ticks >= 28'h0200000) ? 4 : (ticks >= 28'h0004000) ? 3 :
                 (ticks >= 28'h0000080) ? 2 : 1;
        if ((groups < 4) && ($urandom_range(0, 19) == 0))
            append_byte(8'h80);
        for (int i = groups - 1; i >= 0; i--)
            append_byte({i != 0, ticks[7*i +: 7]});
    endtask

    task automatic push_event();
        int         roll;
        int         len;
        logic [7:0] st;
        roll = $urandom_range(0, 99);
        if (big_meta_due)
            roll = 99;
        push_delta(pick_ticks());
        if ((roll < 40) || ((roll < 62) && (gen_status == 8'h00)))
        begin
            st         = 8'($urandom_range(8'h80, SYSTEM_FIRST - 1));
            gen_status = st;
            append_byte(st);
            append_byte(pick_data());
            if (two_data(st))
                append_byte(pick_data());
        end
        else if (roll < 62)
        begin
            append_byte(8'($urandom_range(0, 127)));
            if (two_data(gen_status))
                append_byte(pick_data());
        end
        else if (roll < 72)
            append_byte(8'($urandom_range(SYSTEM_FIRST, STATUS_META - 1)));
        else
        begin
            append_byte(STATUS_META);
            append_byte(($urandom_range(0, 5) == 0) ? META_END : 8'($urandom));
            if (big_meta_due)
                len = 255;
            else if ($urandom_range(0, 3) == 0)
                len = 0;
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(7, 24);
            else
                len = $urandom_range(1, 6);
            big_meta_due = 1'b0;
            append_byte(8'(len));
            repeat (len) append_byte(8'($urandom));
        end
    endtask

    task automatic build_track(input flaw_t kind);
        int events;
        track_q.delete();
        gen_status = 8'h00;
        if (kind == FLAW_NOISE)
        begin
            repeat ($urandom_range(1, 24)) append_byte(8'($urandom));
            return;
        end
        repeat (HEADER_BYTES_DEF) append_byte(8'($urandom));
        if (kind == FLAW_ORPHAN_DATA)
        begin
            append_byte(8'h00);
            append_byte(8'($urandom_range(0, 127)));
        end
        events = $urandom_range(1, 6);
        for (int i = 0; i < events; i++)
        begin
            if ((kind == FLAW_LONG_DELTA) && (i == events - 1))
                repeat (5) append_byte(8'($urandom_range(128, 255)));
            push_event();
        end
        if (kind != FLAW_NO_END)
        begin
            push_delta(pick_ticks());
            append_byte(STATUS_META);
            append_byte(META_END);
            append_byte(8'h00);
        end
        if (kind == FLAW_TRUNCATED)
            repeat ($urandom_range(1, 5)) track_q = track_q[0:$-1];
    endtask

    task automatic send_track(input flaw_t kind);
        int extra_first;
        extra_first = (kind == FLAW_SECOND_FIRST) ? $urandom_range(1, track_q.size() - 1)
                                                  : -1;
        foreach (track_q[i])
            send_byte(track_q[i], (i == 0) || (i == extra_first),
                      (i == track_q.size() - 1) && (kind != FLAW_NO_FINAL), pick_gap());
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        sender_calm   = 1'b1;
        bytes_sent    = 0;
        big_meta_due  = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_byte(8'h00, 1'b1, 1'b1, 0);
        track_q = {8'h4D, 8'h54, 8'h72, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h04,
                   8'h00, STATUS_META, META_END, 8'h00};
        send_track(FLAW_NONE);
        track_q = {8'h4D, 8'h54, 8'h72, 8'h6B, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'h00, 8'h45};
        send_track(FLAW_NONE);
        wait_for_results();

        big_meta_due = 1'b1;
        bytes_sent   = 0;
        while (bytes_sent < STIM_BYTES)
        begin
            if ($urandom_range(0, 5) == 0)
                wait_for_results();
            sender_calm = ($urandom_range(0, 3) == 0);
            flaw = ($urandom_range(0, 99) < 65) ? FLAW_NONE
                                                : flaw_t'($urandom_range(1, 7));
            build_track(flaw);
            send_track(flaw);
        end
        s_axis_tvalid <= 1'b0;

        while (words_pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_midi_track_event_parser: clean");
        else
            $display("tb_midi_track_event_parser: errors");
        $finish;
    end

endmodule
